/* sv/htpb_pkg.sv */
// Shared types, widths and codes for the Huffman tree path builder.
// No dependencies; imported by huffman_tree_path_builder and the testbench.
`timescale 1ns / 1ps

package htpb_pkg;

   // Default sizing of the vocabulary and of the longest path
   localparam int DEF_MAX_WORDS = 1024;
   localparam int DEF_MAX_DEPTH = 40;

   // Fixed field widths
   localparam int CNT_W      = 44;  // stored counts and merged sums
   localparam int WCNT_W     = 32;  // word_count on the input channel
   localparam int IDX_W      = 10;  // word_index and node_index
   localparam int STAT_W     = 3;
   localparam int REQ_DATA_W = 48;  // word_count, word_index, zero pad
   localparam int RSP_DATA_W = 16;  // code_bit, node_index, empty_code, status, pad

   // Request kinds carried in req_tuser
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 3'd2;
   localparam logic [STAT_W-1:0] STAT_DEPTH     = 3'd3;
   localparam logic [STAT_W-1:0] STAT_TOO_MANY  = 3'd4;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD_RD,
      ST_BUILD_PICK,
      ST_WALK_RD,
      ST_WALK_DATA,
      ST_EMIT_RD,
      ST_EMIT_LOAD
   } state_type;

   // Pack one result into the output data word
   function automatic logic [RSP_DATA_W-1:0] pack_rsp(input logic code_bit,
                                                      input logic [IDX_W-1:0] node_index,
                                                      input logic empty_code,
                                                      input logic [STAT_W-1:0] status);
      pack_rsp = {1'b0, status, empty_code, node_index, code_bit};
   endfunction

endpackage

/* sv/huffman_tree_path_builder.sv */
// Huffman tree path builder: loads sorted counts, builds the tree, walks code paths.
// Depends on htpb_pkg (widths, status codes, state type, result packing).
// ---------------------------------------------------------------------------
// Usage
// req channel: req_tuser selects a load (0) or a query (1). A load carries a
//   word count in req_tdata[31:0]; req_tlast marks the final count and starts
//   the tree build. A query carries the word index in req_tdata[41:32].
// rsp channel: one item per path level, root first, rsp_tlast on the final
//   one; loads with req_tlast, overflowing loads and failed queries give one
//   item with a status code; a query on a one-word tree gives one empty-code item.
// Sequencing: a build over V words makes two picks per merged node, each a read
//   and a compare on the dual-read count memory. A query walks the parents
//   through the link memory, a read and a push per level, then replays the
//   path stack, a stack read and an output load per result. One item is in
//   work at a time; req_tready is high only while the sequencer is idle and
//   the output register is free or being emptied.
// Reset: word count and tree-built flag clear; memories hold garbage until
//   written and need no clearing pass.
// Stall: a held rsp item freezes the sequencer at the next result it has to
//   deliver; nothing is dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_tree_path_builder
   import htpb_pkg::*;
#(
   parameter int MAX_WORDS = DEF_MAX_WORDS,
   parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // word_count[31:0], word_index[41:32], zero pad
   input  logic                  req_tuser,   // req_type
   input  logic                  req_tlast,   // last_count
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // code_bit[0], node_index[10:1],
                                              // empty_code[11], status[14:12], zero pad
   output logic                  rsp_tlast    // last
);

   localparam int SLOTS = 2 * MAX_WORDS;
   localparam int NW    = $clog2(SLOTS);
   localparam int WLW   = $clog2(MAX_WORDS + 1);
   localparam int DCW   = $clog2(MAX_DEPTH + 1);
   localparam int DAW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int LNK_W = NW + 1;          // {code bit, parent}
   localparam int STK_W = IDX_W + 1;       // {code bit, inner node index}
   localparam int CMP_W = WLW + IDX_W;

   // Memories
   logic [CNT_W-1:0] cnt_mem  [SLOTS];
   logic [LNK_W-1:0] link_mem [SLOTS];
   logic [STK_W-1:0] stk_mem  [MAX_DEPTH];

   logic [CNT_W-1:0] cnt_rd_a_ff, cnt_rd_b_ff;
   logic [LNK_W-1:0] link_rd_ff;
   logic [STK_W-1:0] stk_rd_ff;

   logic             cnt_we;
   logic [NW-1:0]    cnt_waddr;
   logic [CNT_W-1:0] cnt_wdata;
   logic [NW-1:0]    cnt_raddr_a, cnt_raddr_b;
   logic             link_we;
   logic [NW-1:0]    link_waddr;
   logic [LNK_W-1:0] link_wdata;
   logic             stk_we;
   logic [STK_W-1:0] stk_wdata;
   logic             stk_re;
   logic [DAW-1:0]   stk_raddr;

   // Control and datapath registers
   state_type        state_ff, state_in;
   logic [WLW-1:0]   wl_ff, wl_in;
   logic             tree_ready_ff, tree_ready_in;
   logic [NW-1:0]    root_ff, root_in;
   logic [NW-1:0]    i_ff, i_in;
   logic [WLW-1:0]   leaf_left_ff, leaf_left_in;
   logic [NW-1:0]    merged_ff, merged_in;
   logic             pick_ff, pick_in;
   logic [CNT_W-1:0] pick0_cnt_ff, pick0_cnt_in;
   logic [NW-1:0]    node_ff, node_in;
   logic [DCW-1:0]   depth_ff, depth_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Decoded request fields and helpers
   logic [WCNT_W-1:0] word_count;
   logic [IDX_W-1:0]  word_index;
   logic              out_free;
   logic              accept;
   logic [WLW-1:0]    wl_base;
   logic              full;
   logic [WLW-1:0]    wl_next;
   logic              take_leaf;
   logic [NW-1:0]     pick_idx;
   logic [CNT_W-1:0]  pick_cnt;
   logic [NW-1:0]     parent;
   logic [DCW-1:0]    depth_dec;

   assign word_count = req_tdata[WCNT_W-1:0];
   assign word_index = req_tdata[WCNT_W+IDX_W-1:WCNT_W];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Load bookkeeping: a load after a finished build starts a new vocabulary
   assign wl_base = tree_ready_ff ? '0 : wl_ff;
   assign full    = (wl_base == WLW'(MAX_WORDS));
   assign wl_next = full ? wl_base : WLW'(wl_base + 1'b1);

   // Two-queue pick: leaf on a tie or with no merged node ready, merged node once leaves run out
   assign cnt_raddr_a = NW'(leaf_left_ff - 1'b1);
   assign cnt_raddr_b = merged_ff;
   assign take_leaf   = (leaf_left_ff != '0) &&
                        ((merged_ff >= i_ff) || (cnt_rd_a_ff <= cnt_rd_b_ff));
   assign pick_idx    = take_leaf ? cnt_raddr_a : merged_ff;
   assign pick_cnt    = take_leaf ? cnt_rd_a_ff : cnt_rd_b_ff;

   assign parent    = link_rd_ff[NW-1:0];
   assign depth_dec = DCW'(depth_ff - 1'b1);

   // Next state, datapath updates and memory controls
   always_comb begin
      state_in      = state_ff;
      wl_in         = wl_ff;
      tree_ready_in = tree_ready_ff;
      root_in       = root_ff;
      i_in          = i_ff;
      leaf_left_in  = leaf_left_ff;
      merged_in     = merged_ff;
      pick_in       = pick_ff;
      pick0_cnt_in  = pick0_cnt_ff;
      node_in       = node_ff;
      depth_in      = depth_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      cnt_we        = 1'b0;
      cnt_waddr     = i_ff;
      cnt_wdata     = pick0_cnt_ff + pick_cnt;
      link_we       = 1'b0;
      link_waddr    = pick_idx;
      link_wdata    = {pick_ff, i_ff};
      stk_we        = 1'b0;
      stk_wdata     = {link_rd_ff[NW], IDX_W'(parent - NW'(wl_ff))};
      stk_re        = 1'b0;
      stk_raddr     = depth_dec[DAW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == REQ_LOAD) begin
                  // store the count, answer final or overflowing loads
                  cnt_we        = !full;
                  cnt_waddr     = NW'(wl_base);
                  cnt_wdata     = CNT_W'(word_count);
                  wl_in         = wl_next;
                  tree_ready_in = req_tlast;
                  if (req_tlast) begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_data_in  = pack_rsp(1'b0, '0, wl_next == WLW'(1),
                                             full ? STAT_TOO_MANY : STAT_OK);
                     if (wl_next > WLW'(1)) begin
                        i_in         = NW'(wl_next);
                        merged_in    = NW'(wl_next);
                        leaf_left_in = wl_next;
                        root_in      = NW'({1'b0, wl_next, 1'b0} - 2'd2);
                        pick_in      = 1'b0;
                        state_in     = ST_BUILD_RD;
                     end
                  end else if (full) begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_data_in  = pack_rsp(1'b0, '0, 1'b0, STAT_TOO_MANY);
                  end
               end else begin
                  // query: screen errors, else start the parent walk
                  rsp_last_in = 1'b1;
                  priority if (!tree_ready_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pack_rsp(1'b0, '0, 1'b0,
                                             (wl_ff == '0) ? STAT_EMPTY : STAT_BAD_INDEX);
                  end else if (CMP_W'(word_index) >= CMP_W'(wl_ff)) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pack_rsp(1'b0, '0, 1'b0, STAT_BAD_INDEX);
                  end else if (wl_ff == WLW'(1)) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pack_rsp(1'b0, '0, 1'b1, STAT_OK);
                  end else begin
                     node_in  = NW'(word_index);
                     depth_in = '0;
                     state_in = ST_WALK_RD;
                  end
               end
            end
         end

         ST_BUILD_RD: begin
            // queue heads are being read
            state_in = ST_BUILD_PICK;
         end

         ST_BUILD_PICK: begin
            // take one node, link it to the node under construction
            link_we = 1'b1;
            if (take_leaf) begin
               leaf_left_in = WLW'(leaf_left_ff - 1'b1);
            end else begin
               merged_in = NW'(merged_ff + 1'b1);
            end
            if (!pick_ff) begin
               pick0_cnt_in = pick_cnt;
               pick_in      = 1'b1;
               state_in     = ST_BUILD_RD;
            end else begin
               cnt_we   = 1'b1;
               pick_in  = 1'b0;
               i_in     = NW'(i_ff + 1'b1);
               state_in = (i_ff == root_ff) ? ST_IDLE : ST_BUILD_RD;
            end
         end

         ST_WALK_RD: begin
            // parent of node_ff is being read
            priority if (node_ff == root_ff) begin
               state_in = ST_EMIT_RD;
            end else if (depth_ff == DCW'(MAX_DEPTH)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_data_in  = pack_rsp(1'b0, '0, 1'b0, STAT_DEPTH);
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_WALK_DATA;
            end
         end

         ST_WALK_DATA: begin
            // push this level and climb
            stk_we   = 1'b1;
            node_in  = parent;
            depth_in = DCW'(depth_ff + 1'b1);
            state_in = ST_WALK_RD;
         end

         ST_EMIT_RD: begin
            // replay the stack from the root down
            stk_re   = 1'b1;
            depth_in = depth_dec;
            state_in = ST_EMIT_LOAD;
         end

         ST_EMIT_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (depth_ff == '0);
               rsp_data_in  = pack_rsp(stk_rd_ff[IDX_W], stk_rd_ff[IDX_W-1:0], 1'b0,
                                       STAT_OK);
               state_in     = (depth_ff == '0) ? ST_IDLE : ST_EMIT_RD;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wl_ff         <= '0;
         tree_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wl_ff         <= wl_in;
         tree_ready_ff <= tree_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      root_ff      <= root_in;
      i_ff         <= i_in;
      leaf_left_ff <= leaf_left_in;
      merged_ff    <= merged_in;
      pick_ff      <= pick_in;
      pick0_cnt_ff <= pick0_cnt_in;
      node_ff      <= node_in;
      depth_ff     <= depth_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Count memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_a_ff <= cnt_mem[cnt_raddr_a];
      cnt_rd_b_ff <= cnt_mem[cnt_raddr_b];
   end

   // Link memory: parent and code bit of every non-root node
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[node_ff];
   end

   // Path stack memory
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[depth_ff[DAW-1:0]] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   // Build pointers stay ordered: merged head never passes the node being built
   a_build_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUILD_PICK) |-> (merged_ff <= i_ff) && (i_ff <= root_ff)
                                       && (leaf_left_ff <= wl_ff))
      else $error("build queue pointers out of order");

   // Walk and replay only run on a built tree of at least two words
   a_walk_built: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_RD || state_ff == ST_WALK_DATA || state_ff == ST_EMIT_RD)
      |-> tree_ready_ff && (wl_ff > WLW'(1)))
      else $error("path walk without a built tree");

   // Stack depth bounded by the path limit
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_DATA) |-> (depth_ff < DCW'(MAX_DEPTH)))
      else $error("path stack overflow");

   // The final path result returns the sequencer to idle
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LOAD && out_free && depth_ff == '0)
      |=> (state_ff == ST_IDLE) && rsp_tvalid && rsp_tlast)
      else $error("path run did not close");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for huffman_tree_path_builder: loads sorted counts,
// queries code paths and checks each result against a built-in tree predictor.
// Depends on htpb_pkg (widths, request kinds, status codes) and the RTL only.
`timescale 1ns / 1ps

module testbench;
   import htpb_pkg::*;

   localparam int NODE_SLOTS   = 2 * DEF_MAX_WORDS;
   localparam int RANDOM_ITEMS = 200;
   // longest stretch with no item moving: a build over the largest vocabulary
   // sent here plus a deep path walk and a receiver stall, taken many times over
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 200;

   // how the counts of one vocabulary are drawn
   typedef enum int {SPREAD_TIES, SPREAD_WIDE, SPREAD_CHAIN} spread_type;

   typedef struct packed {
      logic              code_bit;
      logic [IDX_W-1:0]  node_index;
      logic              last;
      logic              empty_code;
      logic [STAT_W-1:0] status;
   } path_step_type;

   // Tree predictor and store of expected path steps
   class path_scoreboard;
      longint unsigned weight[NODE_SLOTS];
      int unsigned     up_link[NODE_SLOTS];
      bit              branch_bit[NODE_SLOTS];
      int unsigned     vocab;
      bit              built;
      path_step_type   steps_due[$];
      int              errors;
      int              checked;
      int              trees;
      int              queries;
      int              deepest;
      int              status_tally[5];

      function int pending();
         return steps_due.size();
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
      endfunction

      function void expect_step(logic code_bit, int unsigned node, logic last,
                                logic empty_code, logic [STAT_W-1:0] status);
         path_step_type s;
         s.code_bit   = code_bit;
         s.node_index = node[IDX_W-1:0];
         s.last       = last;
         s.empty_code = empty_code;
         s.status     = status;
         steps_due.insert(steps_due.size(), s);
         status_tally[status]++;
      endfunction

      // Merge two queues: leaves from the small end, merged nodes in order
      function void merge_nodes();
         int unsigned leaf_left, merged_next, i, p;
         int unsigned picks[2];
         bit take_leaf;
         if (vocab < 2) return;
         leaf_left   = vocab;
         merged_next = vocab;
         for (i = vocab; i < 2 * vocab - 1; i++) begin
            for (p = 0; p < 2; p++) begin
               if (leaf_left == 0) take_leaf = 1'b0;
               else if (merged_next >= i) take_leaf = 1'b1;
               else take_leaf = weight[leaf_left-1] <= weight[merged_next];
               if (take_leaf) begin
                  picks[p] = leaf_left - 1;
                  leaf_left--;
               end else begin
                  picks[p] = merged_next;
                  merged_next++;
               end
            end
            weight[i]            = weight[picks[0]] + weight[picks[1]];
            up_link[picks[0]]    = i;
            up_link[picks[1]]    = i;
            branch_bit[picks[0]] = 1'b0;
            branch_bit[picks[1]] = 1'b1;
         end
      endfunction

      // Work out the results of one accepted request item
      function void note_request(logic kind, logic [WCNT_W-1:0] count,
                                 logic last_count, logic [IDX_W-1:0] index);
         logic [STAT_W-1:0] st;
         int unsigned walk[$];
         int unsigned n, root, node, k;
         if (kind == REQ_LOAD) begin
            st = STAT_OK;
            if (built) begin
               built = 1'b0;
               vocab = 0;
            end
            if (vocab < DEF_MAX_WORDS) begin
               weight[vocab] = count;
               vocab++;
            end else begin
               st = STAT_TOO_MANY;
            end
            if (!last_count) begin
               if (st != STAT_OK) expect_step(1'b0, 0, 1'b1, 1'b0, st);
               return;
            end
            merge_nodes();
            built = 1'b1;
            trees++;
            expect_step(1'b0, 0, 1'b1, vocab == 1, st);
            return;
         end
         queries++;
         if (!built) begin
            expect_step(1'b0, 0, 1'b1, 1'b0, vocab == 0 ? STAT_EMPTY : STAT_BAD_INDEX);
            return;
         end
         if (index >= vocab) begin
            expect_step(1'b0, 0, 1'b1, 1'b0, STAT_BAD_INDEX);
            return;
         end
         if (vocab == 1) begin
            expect_step(1'b0, 0, 1'b1, 1'b1, STAT_OK);
            return;
         end
         // climb to the root, then emit root first
         n    = index;
         root = 2 * vocab - 2;
         while (n != root) begin
            if (walk.size() >= DEF_MAX_DEPTH) begin
               expect_step(1'b0, 0, 1'b1, 1'b0, STAT_DEPTH);
               return;
            end
            walk.insert(walk.size(), n);
            n = up_link[n];
         end
         if (walk.size() > deepest) deepest = walk.size();
         for (k = walk.size(); k > 0; k--) begin
            node = walk[k-1];
            expect_step(branch_bit[node], up_link[node] - vocab, k == 1, 1'b0, STAT_OK);
         end
      endfunction

      // Compare one accepted result with the oldest expected step
      function void check_result(logic [RSP_DATA_W-1:0] data, logic last);
         path_step_type got, want;
         got.code_bit   = data[0];
         got.node_index = data[IDX_W:1];
         got.empty_code = data[IDX_W+1];
         got.status     = data[IDX_W+4:IDX_W+2];
         got.last       = last;
         checked++;
         if (steps_due.size() == 0) begin
            flag($sformatf("unexpected result bit=%0d node=%0d last=%0d empty=%0d status=%0d",
                           got.code_bit, got.node_index, got.last, got.empty_code,
                           got.status));
            return;
         end
         want = steps_due.pop_front();
         if (got !== want)
            flag($sformatf({"result %0d: expected bit=%0d node=%0d last=%0d empty=%0d ",
                            "status=%0d, got bit=%0d node=%0d last=%0d empty=%0d status=%0d"},
                           checked, want.code_bit, want.node_index, want.last,
                           want.empty_code, want.status, got.code_bit, got.node_index,
                           got.last, got.empty_code, got.status));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   path_scoreboard sb;
   int  sent;
   int  idle_cycles;
   bit  send_burst;
   bit  take_burst;

   huffman_tree_path_builder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 11);
   endfunction

   // Check every result item at the edge it is taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   // Count cycles in which no item moves on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Timeout: no item moved for %0d cycles, %0d results still due",
               IDLE_LIMIT, sb.pending());
      $display("Regression FAIL");
      $finish;
   end

   // Result side: stall a random number of cycles before each item
   initial begin : rsp_side
      int gap;
      rsp_tready <= 1'b0;
      take_burst = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
         gap = draw_gap(take_burst);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Drive one request item; called and left at a falling edge
   task automatic push_request(logic kind, logic [WCNT_W-1:0] count, logic last_count,
                               logic [IDX_W-1:0] index);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tlast  <= last_count;
      req_tdata  <= {{(REQ_DATA_W - WCNT_W - IDX_W){1'b0}}, index, count};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, count, last_count, index);
      sent++;
      @(negedge clock);
   endtask

   task automatic query_word(int idx);
      push_request(REQ_QUERY, $urandom(), 1'($urandom_range(0, 1)), idx[IDX_W-1:0]);
   endtask

   // Hold off the sender until every expected result has come
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // Load one vocabulary in descending order, closing it if asked
   task automatic load_vocabulary(int size, spread_type spread, bit close);
      logic [WCNT_W-1:0] counts[$];
      logic [WCNT_W-1:0] fa, fb, fc;
      int i;
      fa = 1;
      fb = 1;
      for (i = 0; i < size; i++) begin
         case (spread)
            SPREAD_TIES: counts.insert(counts.size(), $urandom_range(0, 7));
            SPREAD_WIDE: counts.insert(counts.size(), $urandom());
            default: begin
               // growing like Fibonacci gives the deepest chains
               counts.insert(counts.size(), fa);
               fc = fa + fb;
               fa = fb;
               fb = fc;
            end
         endcase
      end
      counts.rsort();
      for (i = 0; i < size; i++)
         push_request(REQ_LOAD, counts[i], close && (i == size - 1),
                      IDX_W'($urandom_range(0, 1023)));
   endtask

   initial begin : stimulus
      int random_start, scenario, size, nq, i;
      spread_type spread;
      sb = new();
      sent = 0;
      send_burst = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_LOAD;
      req_tlast  <= 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // queries with nothing loaded
      query_word(0);
      query_word(1023);
      // query while the vocabulary is still open
      push_request(REQ_LOAD, 32'hFFFF_FFFF, 1'b0, 10'd0);
      query_word(0);
      // two words, the largest and the smallest count
      push_request(REQ_LOAD, 32'h0000_0000, 1'b1, 10'h3FF);
      query_word(0);
      query_word(1);
      query_word(2);
      query_word(1023);
      // single word has an empty code
      push_request(REQ_LOAD, 32'd5, 1'b1, 10'd0);
      query_word(0);
      query_word(1);
      // few-valued counts that tie often, closed by a zero count: leaves win every tie
      load_vocabulary(3, SPREAD_TIES, 1'b0);
      push_request(REQ_LOAD, 32'd0, 1'b1, 10'd0);
      query_word(0);
      query_word(1);
      query_word(2);
      query_word(3);

      // deep chain: paths up to the depth limit and beyond it
      load_vocabulary(45, SPREAD_CHAIN, 1'b1);
      query_word(0);
      for (i = 36; i < 45; i++) query_word(i);
      drain_results();

      // random vocabularies with random queries, mixed with noise
      random_start = sent;
      while (sent - random_start < RANDOM_ITEMS) begin
         send_burst = ($urandom_range(0, 3) == 0);
         scenario   = $urandom_range(0, 9);
         if (scenario == 0) begin
            // stray queries and loads that leave the vocabulary open
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1)) query_word($urandom_range(0, 1023));
               else push_request(REQ_LOAD, $urandom(), 1'b0,
                                 IDX_W'($urandom_range(0, 1023)));
            end
         end else begin
            size   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 45)
                                                 : $urandom_range(1, 12);
            spread = spread_type'($urandom_range(0, 2));
            load_vocabulary(size, spread, 1'b1);
            nq = $urandom_range(1, 10);
            repeat (nq) begin
               if ($urandom_range(0, 5) == 0) query_word($urandom_range(0, 1023));
               else query_word($urandom_range(0, size - 1));
            end
         end
         if ($urandom_range(0, 4) == 0) drain_results();
      end

      // wait out the last results and any stray ones
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));
      $display("Covered %0d request items (%0d queries), %0d trees built, %0d results checked",
               sent, sb.queries, sb.trees, sb.checked);
      $display("Status mix ok/empty/index/depth/full %0d/%0d/%0d/%0d/%0d, longest path %0d",
               sb.status_tally[0], sb.status_tally[1], sb.status_tally[2],
               sb.status_tally[3], sb.status_tally[4], sb.deepest);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d errors", sb.errors);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/htpb_pkg.sv
sv/huffman_tree_path_builder.sv
tb/testbench.sv
